>>> design/rmq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmq_pkg
// Types, widths and helpers for the rotation matrix to quaternion core.
// ---------------------------------------------------------------------------
package rmq_pkg;

   localparam int FRAC_BITS = 16;
   localparam int IN_W      = 18;
   localparam int T_W       = IN_W + 3;
   localparam int NUM_W     = IN_W + 1;
   localparam int MAG_W     = NUM_W;
   localparam int ROOT_W    = (T_W - 1 + FRAC_BITS + 1) / 2;
   localparam int RAD_W     = 2 * ROOT_W;
   localparam int SQ_REM_W  = ROOT_W + 2;
   localparam int S_W       = ROOT_W + 1;
   localparam int DV_REM_W  = S_W + 1;
   localparam int DIVD_W    = MAG_W + FRAC_BITS;
   localparam int Q_W       = DIVD_W + 2;
   localparam int SQ_STEPS  = ROOT_W;
   localparam int DIV_STEPS = DIVD_W;
   localparam int LANES     = 3;

   localparam logic signed [T_W-1:0] ONE = T_W'(1) << FRAC_BITS;

   typedef enum logic [1:0] {
      BR_TRACE = 2'd0,
      BR_X     = 2'd1,
      BR_Y     = 2'd2,
      BR_Z     = 2'd3
   } branch_type;

   typedef struct packed {
      logic                              valid;
      logic                              degen;
      branch_type                        branch;
      logic [LANES-1:0][NUM_W-1:0]       num;
      logic [RAD_W-1:0]                  rad;
      logic [ROOT_W-1:0]                 root;
      logic [SQ_REM_W-1:0]               rem;
   } sq_type;

   typedef struct packed {
      logic                              valid;
      logic                              degen;
      branch_type                        branch;
      logic [LANES-1:0]                  neg;
      logic [ROOT_W-1:0]                 root;
      logic [S_W-1:0]                    divisor;
      logic [LANES-1:0][DIVD_W-1:0]      acc;
      logic [LANES-1:0][DV_REM_W-1:0]    rem;
   } dv_type;

   function automatic logic [IN_W-1:0] sat_q(input logic signed [Q_W-1:0] v);
      logic signed [Q_W-1:0] hi;
      logic signed [Q_W-1:0] lo;
      hi = Q_W'((64'sd1 <<< (IN_W - 1)) - 64'sd1);
      lo = -Q_W'(64'sd1 <<< (IN_W - 1));
      if (v > hi) begin
         return hi[IN_W-1:0];
      end else if (v < lo) begin
         return lo[IN_W-1:0];
      end
      return v[IN_W-1:0];
   endfunction

endpackage

>>> design/rotation_matrix_to_quaternion_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core
// Shepperd conversion of a Q2.16 rotation matrix to a unit quaternion.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_m_r0c0 .. req_m_r2c2
//   rsp     | out       | rsp_valid/rsp_stall | rsp_quat_w/x/y/z, rsp_degenerate
//
// One transaction enters per cycle while rsp does not stall; the pipeline is a front stage,
// 18 square-root cells, a divisor setup stage, 35 divider cells and the
// output register. The divider cell chain sets the latency.
// Reset clears the valid bits only. A stall on rsp freezes the whole chain
// and raises req_stall in the same cycle while a result is held.
// ---------------------------------------------------------------------------
module rotation_matrix_to_quaternion_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [rmq_pkg::IN_W-1:0]  req_m_r0c0,
   input  logic signed [rmq_pkg::IN_W-1:0]  req_m_r0c1,
   input  logic signed [rmq_pkg::IN_W-1:0]  req_m_r0c2,
   input  logic signed [rmq_pkg::IN_W-1:0]  req_m_r1c0,
   input  logic signed [rmq_pkg::IN_W-1:0]  req_m_r1c1,
   input  logic signed [rmq_pkg::IN_W-1:0]  req_m_r1c2,
   input  logic signed [rmq_pkg::IN_W-1:0]  req_m_r2c0,
   input  logic signed [rmq_pkg::IN_W-1:0]  req_m_r2c1,
   input  logic signed [rmq_pkg::IN_W-1:0]  req_m_r2c2,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [rmq_pkg::IN_W-1:0]  rsp_quat_w,
   output logic signed [rmq_pkg::IN_W-1:0]  rsp_quat_x,
   output logic signed [rmq_pkg::IN_W-1:0]  rsp_quat_y,
   output logic signed [rmq_pkg::IN_W-1:0]  rsp_quat_z,
   output logic                             rsp_degenerate
);

   logic en;

   rmq_pkg::sq_type sq_chain [0:rmq_pkg::SQ_STEPS];
   rmq_pkg::dv_type dv_chain [0:rmq_pkg::DIV_STEPS];

   rmq_pkg::sq_type front_in;
   rmq_pkg::sq_type front_ff;
   rmq_pkg::dv_type mid_in;
   rmq_pkg::dv_type mid_ff;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_degen_ff, rsp_degen_in;
   logic [rmq_pkg::IN_W-1:0]         rsp_w_ff, rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [rmq_pkg::IN_W-1:0]         rsp_w_in, rsp_x_in, rsp_y_in, rsp_z_in;

   // front: branch select, term and numerators
   logic signed [rmq_pkg::T_W-1:0] a00, a11, a22, tr, t;
   logic signed [rmq_pkg::NUM_W-1:0] d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   always_comb begin
      a00 = rmq_pkg::T_W'(req_m_r0c0);
      a11 = rmq_pkg::T_W'(req_m_r1c1);
      a22 = rmq_pkg::T_W'(req_m_r2c2);
      tr  = a00 + a11 + a22;
      d21_12 = rmq_pkg::NUM_W'(req_m_r2c1) - rmq_pkg::NUM_W'(req_m_r1c2);
      d02_20 = rmq_pkg::NUM_W'(req_m_r0c2) - rmq_pkg::NUM_W'(req_m_r2c0);
      d10_01 = rmq_pkg::NUM_W'(req_m_r1c0) - rmq_pkg::NUM_W'(req_m_r0c1);
      s01_10 = rmq_pkg::NUM_W'(req_m_r0c1) + rmq_pkg::NUM_W'(req_m_r1c0);
      s02_20 = rmq_pkg::NUM_W'(req_m_r0c2) + rmq_pkg::NUM_W'(req_m_r2c0);
      s12_21 = rmq_pkg::NUM_W'(req_m_r1c2) + rmq_pkg::NUM_W'(req_m_r2c1);
      front_in = '0;
      front_in.valid = req_valid;
      if (tr > 0) begin
         front_in.branch = rmq_pkg::BR_TRACE;
         t = tr + rmq_pkg::ONE;
         front_in.num = {d10_01, d02_20, d21_12};
      end else if (a00 > a11 && a00 > a22) begin
         front_in.branch = rmq_pkg::BR_X;
         t = rmq_pkg::ONE + a00 - a11 - a22;
         front_in.num = {s02_20, s01_10, d21_12};
      end else if (a11 > a22) begin
         front_in.branch = rmq_pkg::BR_Y;
         t = rmq_pkg::ONE + a11 - a00 - a22;
         front_in.num = {s12_21, s01_10, d02_20};
      end else begin
         front_in.branch = rmq_pkg::BR_Z;
         t = rmq_pkg::ONE + a22 - a00 - a11;
         front_in.num = {s12_21, s02_20, d10_01};
      end
      front_in.degen = (t <= 0);
      if (t > 0) begin
         front_in.rad = rmq_pkg::RAD_W'({t[rmq_pkg::T_W-2:0],
                                         {rmq_pkg::FRAC_BITS{1'b0}}});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff.valid <= 1'b0;
      end else if (en) begin
         front_ff <= front_in;
      end
   end

   assign sq_chain[0] = front_ff;

   for (genvar g = 0; g < rmq_pkg::SQ_STEPS; g++) begin : g_sq
      rmq_sqrt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .cell_in (sq_chain[g]),
         .cell_ff (sq_chain[g+1])
      );
   end

   // divisor setup: s = 2r, dividend = |n| * 2^F + s/2
   always_comb begin
      mid_in = '0;
      mid_in.valid   = sq_chain[rmq_pkg::SQ_STEPS].valid;
      mid_in.degen   = sq_chain[rmq_pkg::SQ_STEPS].degen;
      mid_in.branch  = sq_chain[rmq_pkg::SQ_STEPS].branch;
      mid_in.root    = sq_chain[rmq_pkg::SQ_STEPS].root;
      mid_in.divisor = {sq_chain[rmq_pkg::SQ_STEPS].root, 1'b0};
      for (int i = 0; i < rmq_pkg::LANES; i++) begin
         mid_in.neg[i] = sq_chain[rmq_pkg::SQ_STEPS].num[i][rmq_pkg::NUM_W-1];
         mid_in.acc[i] = {(mid_in.neg[i] ? -sq_chain[rmq_pkg::SQ_STEPS].num[i]
                                         :  sq_chain[rmq_pkg::SQ_STEPS].num[i]),
                          {rmq_pkg::FRAC_BITS{1'b0}}}
                         + rmq_pkg::DIVD_W'(sq_chain[rmq_pkg::SQ_STEPS].root);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff.valid <= 1'b0;
      end else if (en) begin
         mid_ff <= mid_in;
      end
   end

   assign dv_chain[0] = mid_ff;

   for (genvar g = 0; g < rmq_pkg::DIV_STEPS; g++) begin : g_dv
      rmq_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .cell_in (dv_chain[g]),
         .cell_ff (dv_chain[g+1])
      );
   end

   // back end: place components, fix sign, saturate, zero degenerate results
   logic signed [rmq_pkg::Q_W-1:0] lane_q [rmq_pkg::LANES];
   logic signed [rmq_pkg::Q_W-1:0] quarter;
   logic signed [rmq_pkg::Q_W-1:0] q0, q1, q2, q3;
   rmq_pkg::dv_type                last;

   always_comb begin
      last = dv_chain[rmq_pkg::DIV_STEPS];
      for (int i = 0; i < rmq_pkg::LANES; i++) begin
         lane_q[i] = last.neg[i] ? -$signed({2'b00, last.acc[i]})
                                 :  $signed({2'b00, last.acc[i]});
      end
      quarter = rmq_pkg::Q_W'((rmq_pkg::S_W'(last.root) + rmq_pkg::S_W'(1)) >> 1);
      case (last.branch)
         rmq_pkg::BR_TRACE: begin
            q0 = quarter;   q1 = lane_q[0]; q2 = lane_q[1]; q3 = lane_q[2];
         end
         rmq_pkg::BR_X: begin
            q0 = lane_q[0]; q1 = quarter;   q2 = lane_q[1]; q3 = lane_q[2];
         end
         rmq_pkg::BR_Y: begin
            q0 = lane_q[0]; q1 = lane_q[1]; q2 = quarter;   q3 = lane_q[2];
         end
         default: begin
            q0 = lane_q[0]; q1 = lane_q[1]; q2 = lane_q[2]; q3 = quarter;
         end
      endcase
      if (q0 < 0) begin
         q0 = -q0; q1 = -q1; q2 = -q2; q3 = -q3;
      end
      rsp_valid_in = last.valid;
      rsp_degen_in = last.degen;
      if (last.degen) begin
         rsp_w_in = '0; rsp_x_in = '0; rsp_y_in = '0; rsp_z_in = '0;
      end else begin
         rsp_w_in = rmq_pkg::sat_q(q0);
         rsp_x_in = rmq_pkg::sat_q(q1);
         rsp_y_in = rmq_pkg::sat_q(q2);
         rsp_z_in = rmq_pkg::sat_q(q3);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_degen_ff <= rsp_degen_in;
         rsp_w_ff     <= rsp_w_in;
         rsp_x_ff     <= rsp_x_in;
         rsp_y_ff     <= rsp_y_in;
         rsp_z_ff     <= rsp_z_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_degenerate = rsp_degen_ff;
   assign rsp_quat_w     = rsp_w_ff;
   assign rsp_quat_x     = rsp_x_ff;
   assign rsp_quat_y     = rsp_y_ff;
   assign rsp_quat_z     = rsp_z_ff;

`ifndef NO_ASSERTIONS
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_quat_w == 0 && rsp_quat_x == 0 && rsp_quat_y == 0 && rsp_quat_z == 0)
      else $error("degenerate result carries nonzero components");

   a_w_nonneg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_quat_w[rmq_pkg::IN_W-1])
      else $error("scalar part negative");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule

>>> design/rmq_sqrt_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmq_sqrt_cell
// One digit step of the integer square root; takes two radicand bits,
// decides one root bit and hands the transaction to the next cell.
// ---------------------------------------------------------------------------
module rmq_sqrt_cell (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  rmq_pkg::sq_type cell_in,
   output rmq_pkg::sq_type cell_ff
);

   rmq_pkg::sq_type              cell_in_next;
   logic [rmq_pkg::SQ_REM_W-1:0] rem_sh;
   logic [rmq_pkg::SQ_REM_W-1:0] trial;

   always_comb begin
      cell_in_next = cell_in;
      rem_sh = {cell_in.rem[rmq_pkg::SQ_REM_W-3:0],
                cell_in.rad[rmq_pkg::RAD_W-1:rmq_pkg::RAD_W-2]};
      trial  = {cell_in.root, 2'b01};
      cell_in_next.rad = {cell_in.rad[rmq_pkg::RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
         cell_in_next.rem  = rem_sh - trial;
         cell_in_next.root = {cell_in.root[rmq_pkg::ROOT_W-2:0], 1'b1};
      end else begin
         cell_in_next.rem  = rem_sh;
         cell_in_next.root = {cell_in.root[rmq_pkg::ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (en) begin
         cell_ff <= cell_in_next;
      end
   end

endmodule

>>> design/rmq_div_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmq_div_cell
// One restoring division step on three lanes sharing a divisor; the
// dividend register fills with quotient bits from the bottom.
// ---------------------------------------------------------------------------
module rmq_div_cell (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  rmq_pkg::dv_type cell_in,
   output rmq_pkg::dv_type cell_ff
);

   rmq_pkg::dv_type              cell_in_next;
   logic [rmq_pkg::DV_REM_W-1:0] rem_sh;
   logic [rmq_pkg::DV_REM_W-1:0] dsr;

   always_comb begin
      cell_in_next = cell_in;
      rem_sh = '0;
      dsr    = {1'b0, cell_in.divisor};
      for (int i = 0; i < rmq_pkg::LANES; i++) begin
         rem_sh = {cell_in.rem[i][rmq_pkg::DV_REM_W-2:0],
                   cell_in.acc[i][rmq_pkg::DIVD_W-1]};
         if (rem_sh >= dsr) begin
            cell_in_next.rem[i] = rem_sh - dsr;
            cell_in_next.acc[i] = {cell_in.acc[i][rmq_pkg::DIVD_W-2:0], 1'b1};
         end else begin
            cell_in_next.rem[i] = rem_sh;
            cell_in_next.acc[i] = {cell_in.acc[i][rmq_pkg::DIVD_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (en) begin
         cell_ff <= cell_in_next;
      end
   end

endmodule
